// ===== sv/random_attitude_generator_macros.svh =====
// Assertion macros shared by the random attitude generator RTL.
// Included by the modules that carry concurrent assertions; uses clk_i and rst_ni.
`ifndef RANDOM_ATTITUDE_GENERATOR_MACROS_SVH
`define RANDOM_ATTITUDE_GENERATOR_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define RAG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition must never be true at a clock edge outside reset.
`define RAG_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define RAG_ASSERT(label, prop, msg)
`define RAG_ASSERT_NEVER(label, cond, msg)
`endif

`endif

// ===== sv/rag_pkg.sv =====
// Shared types, constants and elaboration-time tables of the random attitude generator.
// Used by rag_mul, rag_sqrt, rag_cordic and random_attitude_generator; depends on nothing.
package rag_pkg;

  // Fixed-point formats.
  localparam int QF             = 60;
  localparam int UNIT_FRAC_BITS = 30;
  localparam int UNIT_SHIFT     = QF - UNIT_FRAC_BITS;

  // CORDIC length and iteration counter width.
  localparam int CORDIC_STEPS = 32;
  localparam int CORDIC_CNT_W = $clog2(CORDIC_STEPS);

  // Square root: one result bit per step.
  localparam int SQRT_STEPS = 61;

  // Generator words that the first six draws after reseeding can touch.
  localparam int SEED_LAST  = 161;
  localparam int LOW_WORDS  = 7;
  localparam int HI_FIRST   = 156;
  localparam int KEEP_WORDS = LOW_WORDS + SEED_LAST - HI_FIRST + 1;
  localparam int DRAWS      = 6;

  localparam logic [63:0] SEED_MUL    = 64'h5851_F42D_4C95_7F2D;
  localparam logic [63:0] TWIST_XOR   = 64'hB502_6F5A_A966_19E9;
  localparam logic [63:0] UPPER_MASK  = 64'hFFFF_FFFF_8000_0000;
  localparam logic [63:0] LOWER_MASK  = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] ONE_Q60     = 64'h1000_0000_0000_0000;
  localparam logic [63:0] PI_Q60      = 64'h3243_F6A8_885A_308D;
  localparam logic [63:0] HALF_PI_Q60 = 64'h1921_FB54_442D_1846;
  localparam logic [63:0] THREE_Q60   = 64'h3000_0000_0000_0000;
  localparam logic [63:0] K_START     = (64'd3 << 60) / 64'd5;

  // Configuration register indexes.
  localparam int          CFG_IDX_W     = 8;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 8'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED_ISSUE,
    ST_SEED_WAIT,
    ST_DRAW,
    ST_OP_ISSUE,
    ST_OP_WAIT,
    ST_FINISH
  } rag_state_e;

  // Operation sequence after the draws.
  typedef enum logic [4:0] {
    OP_SPEED,
    OP_SQRT_R1,
    OP_SQRT_R2,
    OP_Z1,
    OP_CORD1,
    OP_Z2,
    OP_CORD2,
    OP_ZA,
    OP_CORDA,
    OP_QW,
    OP_QX,
    OP_QY,
    OP_QZ,
    OP_VV,
    OP_RAD,
    OP_PX,
    OP_RX,
    OP_PY,
    OP_RY,
    OP_RZ
  } rag_op_e;

  typedef enum logic [1:0] {
    UNIT_MUL,
    UNIT_SQRT,
    UNIT_CORDIC
  } rag_unit_e;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } rag_mul_req_t;

  typedef logic [63:0] rag_tab_t [64];

  // Magnitude of a two's complement word.
  function automatic logic [63:0] mag64(logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  // floor(2^n / d) by restoring long division, for table building only.
  function automatic logic [63:0] pow2_div(int n, int d);
    logic [63:0] q;
    logic [63:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], (b == n)};
      if (rem >= 64'(d)) begin
        rem  = rem - 64'(d);
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // floor(a * b / 2^60), low 64 bits.
  function automatic logic [63:0] umulq(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // Arctangent table: pi/4, then the alternating series for atan(2^-i).
  function automatic rag_tab_t build_atan();
    rag_tab_t    tab;
    logic [63:0] sum;
    logic [63:0] term;
    tab[0] = PI_Q60 >> 2;
    for (int i = 1; i < 64; i++) begin
      sum = '0;
      for (int k = 0; i * (2 * k + 1) <= QF; k++) begin
        term = pow2_div(QF - i * (2 * k + 1), 2 * k + 1);
        sum  = (k % 2 == 1) ? sum - term : sum + term;
      end
      tab[i] = sum;
    end
    return tab;
  endfunction

  // Inverse CORDIC gain by Newton iteration on the gain product.
  function automatic logic [63:0] build_cordic_k();
    logic [63:0] p;
    logic [63:0] y;
    logic [63:0] t;
    p = ONE_Q60;
    for (int i = 0; i < CORDIC_STEPS && 2 * i < 64; i++) begin
      p = p + (p >> (2 * i));
    end
    y = K_START;
    for (int i = 0; i < 8; i++) begin
      t = umulq(p, umulq(y, y));
      y = umulq(y, THREE_Q60 - t) >> 1;
    end
    return y;
  endfunction

  localparam rag_tab_t    ATAN_TAB = build_atan();
  localparam logic [63:0] CORDIC_K = build_cordic_k();

  // One word of the generator's twist.
  function automatic logic [63:0] twist_word(logic [63:0] cur, logic [63:0] nxt,
                                             logic [63:0] mid);
    logic [63:0] x;
    logic [63:0] xa;
    x  = (cur & UPPER_MASK) | (nxt & LOWER_MASK);
    xa = {1'b0, x[63:1]} ^ (x[0] ? TWIST_XOR : 64'd0);
    return mid ^ xa;
  endfunction

  // Output tempering; returns the top 53 bits.
  function automatic logic [52:0] temper(logic [63:0] w);
    logic [63:0] y;
    y = w;
    y = y ^ ((y >> 29) & 64'h5555_5555_5555_5555);
    y = y ^ ((y << 17) & 64'h71D6_7FFF_EDA6_0000);
    y = y ^ ((y << 37) & 64'hFFF7_EEE0_0000_0000);
    y = y ^ (y >> 43);
    return y[63:11];
  endfunction

endpackage

// ===== sv/rag_mul.sv =====
// Shared 64x64 unsigned multiplier built from one 32x32 multiplier, taking four partial products in turn.
// Depends on rag_pkg for the request struct.
module rag_mul (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rag_pkg::rag_mul_req_t req_i,
  output logic                  done_o,
  output logic [127:0]          prod_o
);

  localparam logic [2:0] PARTS = 3'd4;

  logic [63:0]  a_q, b_q;
  logic [63:0]  pp_q;
  logic [1:0]   psh_q;
  logic [127:0] acc_q;
  logic [2:0]   cnt_q;
  logic         busy_q, pv_q, done_q;
  logic [31:0]  a_part, b_part;
  logic [127:0] pp_shifted;

  // Partial product order: a0*b0, a0*b1, a1*b0, a1*b1.
  assign a_part = cnt_q[1] ? a_q[63:32] : a_q[31:0];
  assign b_part = cnt_q[0] ? b_q[63:32] : b_q[31:0];

  // Align the registered partial product to its weight.
  always_comb begin
    case (psh_q)
      2'd0:    pp_shifted = {64'd0, pp_q};
      2'd3:    pp_shifted = {pp_q, 64'd0};
      default: pp_shifted = {32'd0, pp_q, 32'd0};
    endcase
  end

  // Control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pv_q   <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      pv_q   <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (busy_q) begin
      if (cnt_q != PARTS) begin
        cnt_q <= cnt_q + 3'd1;
        pv_q  <= 1'b1;
      end else begin
        pv_q <= 1'b0;
      end
      done_q <= pv_q && (cnt_q == PARTS);
      if (pv_q && (cnt_q == PARTS)) begin
        busy_q <= 1'b0;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Operands, partial product and accumulator.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      acc_q <= '0;
    end else begin
      if (busy_q && (cnt_q != PARTS)) begin
        pp_q  <= {32'd0, a_part} * {32'd0, b_part};
        psh_q <= cnt_q[1:0];
      end
      if (pv_q) begin
        acc_q <= acc_q + pp_shifted;
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== sv/rag_sqrt.sv =====
// Bit-serial square root: floor(sqrt(v * 2^60)) for a Q60 argument clamped to [0, 1].
// Depends on rag_pkg for the format constants.
module rag_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] v_i,
  output logic        done_o,
  output logic [63:0] root_o
);

  localparam logic [5:0] LAST = 6'(rag_pkg::SQRT_STEPS - 1);

  logic [121:0] rad_q;
  logic [63:0]  rem_q;
  logic [60:0]  root_q;
  logic [5:0]   cnt_q;
  logic         busy_q, done_q;
  logic [60:0]  v_clamped;
  logic [63:0]  rem_sh, trial;
  logic         ge;

  // Clamp the argument into [0, 1].
  always_comb begin
    if (v_i[63]) begin
      v_clamped = '0;
    end else if (v_i > rag_pkg::ONE_Q60) begin
      v_clamped = rag_pkg::ONE_Q60[60:0];
    end else begin
      v_clamped = v_i[60:0];
    end
  end

  // One restoring step per cycle.
  assign rem_sh = {rem_q[61:0], rad_q[121:120]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q  <= cnt_q + 6'd1;
      done_q <= (cnt_q == LAST);
      if (cnt_q == LAST) begin
        busy_q <= 1'b0;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // The radicand is v * 2^60, consumed two bits per step from the top.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= {1'b0, v_clamped, 60'd0};
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[119:0], 2'b00};
      rem_q  <= ge ? rem_sh - trial : rem_sh;
      root_q <= {root_q[59:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = {3'd0, root_q};

endmodule

// ===== sv/rag_cordic.sv =====
// Rotation-mode CORDIC, one iteration per cycle, with quadrant folding of the result.
// Depends on rag_pkg for the arctangent table, the gain constant and the step count.
module rag_cordic (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] z_i,
  input  logic [1:0]  quad_i,
  output logic        done_o,
  output logic [63:0] cos_o,
  output logic [63:0] sin_o
);

  localparam logic [rag_pkg::CORDIC_CNT_W-1:0] LAST =
    rag_pkg::CORDIC_CNT_W'(rag_pkg::CORDIC_STEPS - 1);

  logic signed [63:0] x_q, y_q, z_q;
  logic signed [63:0] x_sh, y_sh;
  logic [63:0]        ang;
  logic [1:0]         quad_q;
  logic [rag_pkg::CORDIC_CNT_W-1:0] cnt_q;
  logic               busy_q, done_q;

  assign x_sh = x_q >>> cnt_q;
  assign y_sh = y_q >>> cnt_q;
  assign ang  = rag_pkg::ATAN_TAB[6'(cnt_q)];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q  <= cnt_q + 1'b1;
      done_q <= (cnt_q == LAST);
      if (cnt_q == LAST) begin
        busy_q <= 1'b0;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Micro-rotation toward zero residual angle.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= rag_pkg::CORDIC_K;
      y_q    <= '0;
      z_q    <= z_i;
      quad_q <= quad_i;
    end else if (busy_q) begin
      if (!z_q[63]) begin
        x_q <= x_q - y_sh;
        y_q <= y_q + x_sh;
        z_q <= z_q - ang;
      end else begin
        x_q <= x_q + y_sh;
        y_q <= y_q - x_sh;
        z_q <= z_q + ang;
      end
    end
  end

  // Fold the first-quadrant result into the chosen quadrant.
  always_comb begin
    case (quad_q)
      2'd0: begin
        cos_o = x_q;
        sin_o = y_q;
      end
      2'd1: begin
        cos_o = 64'd0 - y_q;
        sin_o = x_q;
      end
      2'd2: begin
        cos_o = 64'd0 - x_q;
        sin_o = 64'd0 - y_q;
      end
      default: begin
        cos_o = y_q;
        sin_o = 64'd0 - x_q;
      end
    endcase
  end

  assign done_o = done_q;

endmodule

// ===== sv/random_attitude_generator.sv =====
// Random attitude generator: one seed in, one unit quaternion and angular rate out.
// A result is ready after reseeding and the operation sequence: 161 chained generator words
// on the shared multiplier, then the draw state, fourteen products, three square roots and
// three CORDIC runs. A bounds error result skips all of these and goes straight to finish.
// A new seed is taken only in idle, once the previous result has been loaded for output.
// Reset clears the speed bounds to zero and returns the sequencer to idle.
`include "random_attitude_generator_macros.svh"

module random_attitude_generator (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Seed input.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,   // seed[63:0]
  // Result output.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // quat_w[31:0], quat_x[63:32], quat_y[95:64], quat_z[127:96],
  // rate_x[160:128], rate_y[193:161], rate_z[226:194], zero fill[231:227]
  output logic [231:0] m_axis_tdata,
  output logic [0:0]   m_axis_tuser,   // bounds_error[0]
  // Configuration writes.
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [rag_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  localparam logic [7:0] SEED_LAST_IDX = 8'(rag_pkg::SEED_LAST);
  localparam logic [7:0] LOW_LAST_IDX  = 8'(rag_pkg::LOW_WORDS - 1);
  localparam logic [7:0] HI_FIRST_IDX  = 8'(rag_pkg::HI_FIRST);
  localparam logic [7:0] HI_OFFSET     = 8'(rag_pkg::HI_FIRST - rag_pkg::LOW_WORDS);

  rag_pkg::rag_state_e state_q, state_d;
  rag_pkg::rag_op_e    op_q;
  rag_pkg::rag_unit_e  op_unit;
  rag_pkg::rag_mul_req_t mul_req;

  logic [7:0]  seed_idx_q;
  logic [63:0] p_q;
  logic [63:0] w_q [rag_pkg::KEEP_WORDS];
  logic [52:0] u_q [rag_pkg::DRAWS];
  logic [31:0] min_q, max_q, speed_q;
  logic [63:0] r1_q, r2_q, c1_q, s1_q, c2_q, s2_q, ca_q, sa_q;
  logic [63:0] zin_q, tmp_q, rad_q;
  logic [31:0] qw_q, qx_q, qy_q, qz_q;
  logic [32:0] rx_q, ry_q, rz_q;
  logic        err_q;
  logic [231:0] tdata_q;
  logic         tuser_q, tvalid_q;

  logic         in_xfer, bounds_bad, load_out, unit_done;
  logic [63:0]  t1, vz;
  logic [63:0]  op_a, op_b, sqrt_v;
  logic         op_neg;
  logic [1:0]   cord_quad;
  logic         sqrt_start, cord_start;

  logic         mul_done, sqrt_done, cord_done;
  logic [127:0] mul_prod;
  logic [63:0]  sqrt_root, cord_cos, cord_sin;

  logic [63:0]  seed_new;
  logic         seed_keep;
  logic [3:0]   seed_widx;
  logic [63:0]  smag, smul_val, usum;
  logic [31:0]  umag, unit_val, speed_val;
  logic [95:0]  rsum;
  logic [32:0]  rmag, rate_val;

  assign in_xfer    = s_axis_tvalid && s_axis_tready;
  assign bounds_bad = max_q < min_q;
  assign load_out   = (state_q == rag_pkg::ST_FINISH) && (!tvalid_q || m_axis_tready);

  // Q60 views of the draws that feed the square roots and the z rate.
  assign t1 = {4'd0, u_q[1], 7'd0};
  assign vz = {3'd0, u_q[4], 8'd0} - rag_pkg::ONE_Q60;

  // Operation decode: unit, operands and result sign.
  always_comb begin
    op_unit   = rag_pkg::UNIT_MUL;
    op_a      = '0;
    op_b      = '0;
    op_neg    = 1'b0;
    sqrt_v    = '0;
    cord_quad = '0;
    case (op_q)
      rag_pkg::OP_SPEED: begin
        op_a = {32'd0, max_q - min_q};
        op_b = {11'd0, u_q[0]};
      end
      rag_pkg::OP_SQRT_R1: begin
        op_unit = rag_pkg::UNIT_SQRT;
        sqrt_v  = rag_pkg::ONE_Q60 - t1;
      end
      rag_pkg::OP_SQRT_R2: begin
        op_unit = rag_pkg::UNIT_SQRT;
        sqrt_v  = t1;
      end
      rag_pkg::OP_Z1: begin
        op_a = {13'd0, u_q[2][50:0]};
        op_b = rag_pkg::HALF_PI_Q60;
      end
      rag_pkg::OP_CORD1: begin
        op_unit   = rag_pkg::UNIT_CORDIC;
        cord_quad = u_q[2][52:51];
      end
      rag_pkg::OP_Z2: begin
        op_a = {13'd0, u_q[3][50:0]};
        op_b = rag_pkg::HALF_PI_Q60;
      end
      rag_pkg::OP_CORD2: begin
        op_unit   = rag_pkg::UNIT_CORDIC;
        cord_quad = u_q[3][52:51];
      end
      rag_pkg::OP_ZA: begin
        op_a = {13'd0, u_q[5][50:0]};
        op_b = rag_pkg::HALF_PI_Q60;
      end
      rag_pkg::OP_CORDA: begin
        op_unit   = rag_pkg::UNIT_CORDIC;
        cord_quad = u_q[5][52:51];
      end
      rag_pkg::OP_QW: begin
        op_a   = rag_pkg::mag64(r2_q);
        op_b   = rag_pkg::mag64(c2_q);
        op_neg = r2_q[63] ^ c2_q[63];
      end
      rag_pkg::OP_QX: begin
        op_a   = rag_pkg::mag64(r1_q);
        op_b   = rag_pkg::mag64(s1_q);
        op_neg = r1_q[63] ^ s1_q[63];
      end
      rag_pkg::OP_QY: begin
        op_a   = rag_pkg::mag64(r1_q);
        op_b   = rag_pkg::mag64(c1_q);
        op_neg = r1_q[63] ^ c1_q[63];
      end
      rag_pkg::OP_QZ: begin
        op_a   = rag_pkg::mag64(r2_q);
        op_b   = rag_pkg::mag64(s2_q);
        op_neg = r2_q[63] ^ s2_q[63];
      end
      rag_pkg::OP_VV: begin
        op_a = rag_pkg::mag64(vz);
        op_b = rag_pkg::mag64(vz);
      end
      rag_pkg::OP_RAD: begin
        op_unit = rag_pkg::UNIT_SQRT;
        sqrt_v  = rag_pkg::ONE_Q60 - tmp_q;
      end
      rag_pkg::OP_PX: begin
        op_a   = rag_pkg::mag64(rad_q);
        op_b   = rag_pkg::mag64(ca_q);
        op_neg = rad_q[63] ^ ca_q[63];
      end
      rag_pkg::OP_PY: begin
        op_a   = rag_pkg::mag64(rad_q);
        op_b   = rag_pkg::mag64(sa_q);
        op_neg = rad_q[63] ^ sa_q[63];
      end
      rag_pkg::OP_RX, rag_pkg::OP_RY: begin
        op_a   = {32'd0, speed_q};
        op_b   = rag_pkg::mag64(tmp_q);
        op_neg = tmp_q[63];
      end
      rag_pkg::OP_RZ: begin
        op_a   = {32'd0, speed_q};
        op_b   = rag_pkg::mag64(vz);
        op_neg = vz[63];
      end
      default: begin
        op_unit = rag_pkg::UNIT_MUL;
      end
    endcase
  end

  always_comb begin
    case (op_unit)
      rag_pkg::UNIT_SQRT:   unit_done = sqrt_done;
      rag_pkg::UNIT_CORDIC: unit_done = cord_done;
      default:              unit_done = mul_done;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      rag_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_d = bounds_bad ? rag_pkg::ST_FINISH : rag_pkg::ST_SEED_ISSUE;
        end
      end
      rag_pkg::ST_SEED_ISSUE: state_d = rag_pkg::ST_SEED_WAIT;
      rag_pkg::ST_SEED_WAIT: begin
        if (mul_done) begin
          state_d = (seed_idx_q == SEED_LAST_IDX) ? rag_pkg::ST_DRAW
                                                  : rag_pkg::ST_SEED_ISSUE;
        end
      end
      rag_pkg::ST_DRAW:     state_d = rag_pkg::ST_OP_ISSUE;
      rag_pkg::ST_OP_ISSUE: state_d = rag_pkg::ST_OP_WAIT;
      rag_pkg::ST_OP_WAIT: begin
        if (unit_done) begin
          state_d = (op_q == rag_pkg::OP_RZ) ? rag_pkg::ST_FINISH : rag_pkg::ST_OP_ISSUE;
        end
      end
      rag_pkg::ST_FINISH: begin
        if (load_out) begin
          state_d = rag_pkg::ST_IDLE;
        end
      end
      default: state_d = rag_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and unit starts.
  always_comb begin
    s_axis_tready = (state_q == rag_pkg::ST_IDLE);
    mul_req.start = (state_q == rag_pkg::ST_SEED_ISSUE) ||
                    ((state_q == rag_pkg::ST_OP_ISSUE) && (op_unit == rag_pkg::UNIT_MUL));
    sqrt_start    = (state_q == rag_pkg::ST_OP_ISSUE) && (op_unit == rag_pkg::UNIT_SQRT);
    cord_start    = (state_q == rag_pkg::ST_OP_ISSUE) && (op_unit == rag_pkg::UNIT_CORDIC);
    if (state_q == rag_pkg::ST_SEED_ISSUE) begin
      mul_req.a = p_q ^ {62'd0, p_q[63:62]};
      mul_req.b = rag_pkg::SEED_MUL;
    end else begin
      mul_req.a = op_a;
      mul_req.b = op_b;
    end
  end

  rag_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  rag_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .v_i     (sqrt_v),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  rag_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .z_i     (zin_q),
    .quad_i  (cord_quad),
    .done_o  (cord_done),
    .cos_o   (cord_cos),
    .sin_o   (cord_sin)
  );

  // Next seeding word and where it is kept.
  assign seed_new  = mul_prod[63:0] + {56'd0, seed_idx_q};
  assign seed_keep = (seed_idx_q <= LOW_LAST_IDX) || (seed_idx_q >= HI_FIRST_IDX);
  assign seed_widx = (seed_idx_q <= LOW_LAST_IDX) ? seed_idx_q[3:0]
                                                  : 4'(seed_idx_q - HI_OFFSET);

  // Product post-processing: signed Q60, quaternion rounding, rate rounding, speed.
  assign smag      = {1'b0, mul_prod[122:60]};
  assign smul_val  = op_neg ? (64'd0 - smag) : smag;
  assign usum      = smag + (64'd1 << (rag_pkg::UNIT_SHIFT - 1));
  assign umag      = usum[rag_pkg::UNIT_SHIFT +: 32];
  assign unit_val  = op_neg ? (32'd0 - umag) : umag;
  assign rsum      = mul_prod[95:0] + (96'd1 << (rag_pkg::QF - 1));
  assign rmag      = rsum[rag_pkg::QF +: 33];
  assign rate_val  = op_neg ? (33'd0 - rmag) : rmag;
  assign speed_val = min_q + mul_prod[84:53];

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= rag_pkg::ST_IDLE;
      op_q       <= rag_pkg::OP_SPEED;
      seed_idx_q <= '0;
      tvalid_q   <= 1'b0;
      min_q      <= '0;
      max_q      <= '0;
    end else begin
      state_q <= state_d;
      if (in_xfer) begin
        seed_idx_q <= 8'd1;
      end else if ((state_q == rag_pkg::ST_SEED_WAIT) && mul_done) begin
        seed_idx_q <= seed_idx_q + 8'd1;
      end
      if (state_q == rag_pkg::ST_DRAW) begin
        op_q <= rag_pkg::OP_SPEED;
      end else if ((state_q == rag_pkg::ST_OP_WAIT) && unit_done &&
                   (op_q != rag_pkg::OP_RZ)) begin
        op_q <= rag_pkg::rag_op_e'(op_q + 5'd1);
      end
      if (load_out) begin
        tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        tvalid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          rag_pkg::REG_MIN_SPEED: min_q <= cfg_data_i;
          rag_pkg::REG_MAX_SPEED: max_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Seeding, draws and results.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      err_q  <= bounds_bad;
      p_q    <= s_axis_tdata;
      w_q[0] <= s_axis_tdata;
    end
    if ((state_q == rag_pkg::ST_SEED_WAIT) && mul_done) begin
      p_q <= seed_new;
      if (seed_keep) begin
        w_q[seed_widx] <= seed_new;
      end
    end
    if (state_q == rag_pkg::ST_DRAW) begin
      for (int i = 0; i < rag_pkg::DRAWS; i++) begin
        u_q[i] <= rag_pkg::temper(rag_pkg::twist_word(w_q[i], w_q[i + 1],
                                                      w_q[i + rag_pkg::LOW_WORDS]));
      end
    end
    if ((state_q == rag_pkg::ST_OP_WAIT) && unit_done) begin
      case (op_q)
        rag_pkg::OP_SPEED:   speed_q <= speed_val;
        rag_pkg::OP_SQRT_R1: r1_q <= sqrt_root;
        rag_pkg::OP_SQRT_R2: r2_q <= sqrt_root;
        rag_pkg::OP_Z1, rag_pkg::OP_Z2, rag_pkg::OP_ZA: zin_q <= mul_prod[114:51];
        rag_pkg::OP_CORD1: begin
          c1_q <= cord_cos;
          s1_q <= cord_sin;
        end
        rag_pkg::OP_CORD2: begin
          c2_q <= cord_cos;
          s2_q <= cord_sin;
        end
        rag_pkg::OP_CORDA: begin
          ca_q <= cord_cos;
          sa_q <= cord_sin;
        end
        rag_pkg::OP_QW: qw_q <= unit_val;
        rag_pkg::OP_QX: qx_q <= unit_val;
        rag_pkg::OP_QY: qy_q <= unit_val;
        rag_pkg::OP_QZ: qz_q <= unit_val;
        rag_pkg::OP_VV, rag_pkg::OP_PX, rag_pkg::OP_PY: tmp_q <= smul_val;
        rag_pkg::OP_RAD: rad_q <= sqrt_root;
        rag_pkg::OP_RX:  rx_q <= rate_val;
        rag_pkg::OP_RY:  ry_q <= rate_val;
        rag_pkg::OP_RZ:  rz_q <= rate_val;
        default: ;
      endcase
    end
    if (load_out) begin
      tdata_q <= err_q ? '0 : {5'd0, rz_q, ry_q, rx_q, qz_q, qy_q, qx_q, qw_q};
      tuser_q <= err_q;
    end
  end

  assign m_axis_tvalid   = tvalid_q;
  assign m_axis_tdata    = tdata_q;
  assign m_axis_tuser[0] = tuser_q;
  assign cfg_ready_o     = 1'b1;

  // An error result carries all-zero data.
  `RAG_ASSERT(a_err_zero, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0,
              "bounds error result with nonzero data")
  // No unit reports completion while the sequencer is idle.
  `RAG_ASSERT_NEVER(a_done_idle, (mul_done || sqrt_done || cord_done) &&
                    (state_q == rag_pkg::ST_IDLE), "unit completion while idle")
  // A seed transfer always leaves idle.
  `RAG_ASSERT(a_xfer_busy, in_xfer |=> state_q != rag_pkg::ST_IDLE,
              "sequencer stayed idle after a seed transfer")
  // Seeding never runs past the last needed word.
  `RAG_ASSERT_NEVER(a_seed_range, (state_q == rag_pkg::ST_SEED_WAIT) &&
                    (seed_idx_q > SEED_LAST_IDX), "seeding index out of range")

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for random_attitude_generator: drives seeds and speed bounds,
// predicts each attitude and rate result in its own fixed-point model and compares them.
// Depends on rag_pkg for the configuration register indexes and the DUT itself.
module tb_top;

  typedef struct {
    logic [31:0] qw, qx, qy, qz;
    logic [32:0] rx, ry, rz;
    logic        berr;
  } attitude_t;

  localparam logic [63:0] Q_ONE    = 64'h1000_0000_0000_0000;
  localparam logic [63:0] Q_PI     = 64'h3243_F6A8_885A_308D;
  localparam logic [63:0] Q_HALFPI = 64'h1921_FB54_442D_1846;
  localparam logic [63:0] MT_MUL   = 64'h5851_F42D_4C95_7F2D;
  localparam logic [63:0] MT_XOR   = 64'hB502_6F5A_A966_19E9;
  localparam int          N_MT     = 312;
  localparam int          N_MID    = 156;
  localparam int          N_ROT    = 32;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic         seed_valid = 1'b0;
  logic         seed_ready;
  logic [63:0]  seed_data = '0;
  logic         res_valid;
  logic         res_ready = 1'b0;
  logic [231:0] res_data;
  logic [0:0]   res_user;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [rag_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  random_attitude_generator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (seed_valid),
    .s_axis_tready (seed_ready),
    .s_axis_tdata  (seed_data),
    .m_axis_tvalid (res_valid),
    .m_axis_tready (res_ready),
    .m_axis_tdata  (res_data),
    .m_axis_tuser  (res_user),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Predictor state.
  logic [63:0] atan_q [64];
  logic [63:0] gain_inv;
  logic [63:0] mt_words [N_MT];
  int          mt_pos;
  logic [31:0] lo_speed = '0;
  logic [31:0] hi_speed = '0;

  logic [63:0] seed_q [$];
  attitude_t   attitude_q [$];
  int          errors = 0;
  bit          seed_fired = 0;
  bit          res_fired = 0;
  bit          no_idle = 0;
  int          seed_gap = 0;
  int          res_stall = 0;

  function automatic logic [63:0] q_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // Signed Q60 product, truncated toward zero.
  function automatic logic [63:0] q_smul(logic [63:0] a, logic [63:0] b);
    logic [63:0] ma, mb, m;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    m = q_mul(ma, mb) & 64'h7FFF_FFFF_FFFF_FFFF;
    return (a[63] != b[63]) ? -m : m;
  endfunction

  function automatic logic [63:0] q_sqrt(logic [63:0] t);
    logic [63:0] v, root, rem, trial;
    logic [127:0] n;
    v = t[63] ? 64'd0 : t;
    if (v > Q_ONE) v = Q_ONE;
    n = {64'd0, v} << 60;
    root = 0;
    rem = 0;
    for (int i = 60; i >= 0; i--) begin
      rem = (rem << 2) | 64'((n >> (2 * i)) & 128'd3);
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  // Cosine and sine of a full turn scaled by u / 2^53.
  task automatic turn_sincos(input logic [52:0] u, output logic [63:0] c,
                             output logic [63:0] s);
    logic [127:0] p;
    logic signed [63:0] x, y, z, nx;
    p = {77'd0, u[50:0]} * {64'd0, Q_HALFPI};
    z = p[114:51];
    x = gain_inv;
    y = 0;
    for (int i = 0; i < N_ROT; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z = z - atan_q[i];
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z = z + atan_q[i];
      end
      x = nx;
    end
    case (u[52:51])
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  function automatic logic [52:0] mt_draw();
    logic [63:0] x, xa, y;
    if (mt_pos >= N_MT) begin
      for (int i = 0; i < N_MT; i++) begin
        x = (mt_words[i] & 64'hFFFF_FFFF_8000_0000)
          | (mt_words[(i + 1) % N_MT] & 64'h0000_0000_7FFF_FFFF);
        xa = (x >> 1) ^ (x[0] ? MT_XOR : 64'd0);
        mt_words[i] = mt_words[(i + N_MID) % N_MT] ^ xa;
      end
      mt_pos = 0;
    end
    y = mt_words[mt_pos];
    mt_pos++;
    y = y ^ ((y >> 29) & 64'h5555_5555_5555_5555);
    y = y ^ ((y << 17) & 64'h71D6_7FFF_EDA6_0000);
    y = y ^ ((y << 37) & 64'hFFF7_EEE0_0000_0000);
    y = y ^ (y >> 43);
    return y[63:11];
  endfunction

  function automatic logic [31:0] unit_round(logic [63:0] v);
    logic [63:0] m;
    m = v[63] ? -v : v;
    m = (m + (64'd1 << 29)) >> 30;
    return v[63] ? 32'(-m) : 32'(m);
  endfunction

  function automatic logic [32:0] rate_round(logic [63:0] speed, logic [63:0] v);
    logic [63:0] m, r;
    logic [127:0] p;
    m = v[63] ? -v : v;
    p = {64'd0, speed} * {64'd0, m} + (128'd1 << 59);
    r = p[123:60];
    return v[63] ? 33'(-r) : 33'(r);
  endfunction

  // Expected result for one seed under the current speed bounds.
  task automatic predict_attitude(input logic [63:0] seed, output attitude_t e);
    logic [52:0] u0, u1, u2, u3, u4, u5;
    logic [63:0] p, speed, t1, r1, r2, c1, s1, c2, s2, vz, radial, ca, sa;
    logic [127:0] span;
    e = '{default: '0};
    if (hi_speed < lo_speed) begin
      e.berr = 1'b1;
      return;
    end
    mt_words[0] = seed;
    for (int i = 1; i < N_MT; i++) begin
      p = mt_words[i - 1];
      mt_words[i] = MT_MUL * (p ^ (p >> 62)) + 64'(i);
    end
    mt_pos = N_MT;
    u0 = mt_draw(); u1 = mt_draw(); u2 = mt_draw();
    u3 = mt_draw(); u4 = mt_draw(); u5 = mt_draw();
    span = {96'd0, hi_speed - lo_speed} * {75'd0, u0};
    speed = 64'(lo_speed) + 64'(span >> 53);
    t1 = {u1, 11'd0} >> 4;
    r1 = q_sqrt(Q_ONE - t1);
    r2 = q_sqrt(t1);
    turn_sincos(u2, c1, s1);
    turn_sincos(u3, c2, s2);
    e.qw = unit_round(q_smul(r2, c2));
    e.qx = unit_round(q_smul(r1, s1));
    e.qy = unit_round(q_smul(r1, c1));
    e.qz = unit_round(q_smul(r2, s2));
    vz = ({u4, 11'd0} >> 3) - Q_ONE;
    radial = q_sqrt(Q_ONE - q_smul(vz, vz));
    turn_sincos(u5, ca, sa);
    e.rx = rate_round(speed, q_smul(radial, ca));
    e.ry = rate_round(speed, q_smul(radial, sa));
    e.rz = rate_round(speed, vz);
  endtask

  // Arctangent table and inverse gain, built once.
  initial begin : build_consts
    logic signed [63:0] sum, term;
    logic [63:0] p, y, t;
    atan_q[0] = Q_PI >> 2;
    for (int i = 1; i < 64; i++) begin
      sum = 0;
      for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
        term = (64'd1 << (60 - i * (2 * k + 1))) / (2 * k + 1);
        sum = (k % 2 == 1) ? sum - term : sum + term;
      end
      atan_q[i] = sum;
    end
    p = Q_ONE;
    for (int i = 0; i < N_ROT; i++) p = p + (p >> (2 * i));
    y = (64'd3 << 60) / 64'd5;
    for (int i = 0; i < 8; i++) begin
      t = q_mul(p, q_mul(y, y));
      y = q_mul(y, (64'd3 << 60) - t) >> 1;
    end
    gain_inv = y;
  end

  // Monitor: records every transfer, predicts on seed transfers, checks results.
  always @(posedge clk_i) begin : monitor
    attitude_t e;
    seed_fired = seed_valid && seed_ready;
    res_fired = res_valid && res_ready;
    if (rst_ni && cfg_valid && cfg_ready) begin
      if (cfg_index == rag_pkg::REG_MIN_SPEED) lo_speed = cfg_data;
      else if (cfg_index == rag_pkg::REG_MAX_SPEED) hi_speed = cfg_data;
    end
    if (rst_ni && seed_fired) begin
      predict_attitude(seed_data, e);
      attitude_q.push_back(e);
    end
    if (rst_ni && res_fired) begin
      if (attitude_q.size() == 0) begin
        $error("result transfer with no expected result");
        errors++;
      end else begin
        e = attitude_q.pop_front();
        if (res_data[31:0] !== e.qw) begin
          $error("quat_w expected %h got %h", e.qw, res_data[31:0]); errors++;
        end
        if (res_data[63:32] !== e.qx) begin
          $error("quat_x expected %h got %h", e.qx, res_data[63:32]); errors++;
        end
        if (res_data[95:64] !== e.qy) begin
          $error("quat_y expected %h got %h", e.qy, res_data[95:64]); errors++;
        end
        if (res_data[127:96] !== e.qz) begin
          $error("quat_z expected %h got %h", e.qz, res_data[127:96]); errors++;
        end
        if (res_data[160:128] !== e.rx) begin
          $error("rate_x expected %h got %h", e.rx, res_data[160:128]); errors++;
        end
        if (res_data[193:161] !== e.ry) begin
          $error("rate_y expected %h got %h", e.ry, res_data[193:161]); errors++;
        end
        if (res_data[226:194] !== e.rz) begin
          $error("rate_z expected %h got %h", e.rz, res_data[226:194]); errors++;
        end
        if (res_user[0] !== e.berr) begin
          $error("bounds_error expected %b got %b", e.berr, res_user[0]); errors++;
        end
      end
    end
  end

  // Seed driver: one queued seed per transfer, with a random gap after each unless no_idle is set.
  always @(negedge clk_i) begin : seed_driver
    logic nv;
    nv = seed_valid;
    if (rst_ni) begin
      if (seed_valid && seed_fired) nv = 1'b0;
      if (!nv) begin
        if (seed_gap > 0) begin
          seed_gap--;
        end else if (seed_q.size() > 0) begin
          seed_data <= seed_q.pop_front();
          nv = 1'b1;
          seed_gap = no_idle ? 0 : $urandom_range(0, 12);
        end
      end
    end
    seed_valid <= nv;
  end

  // Result sink: random stall after each result transfer unless no_idle is set.
  always @(negedge clk_i) begin : result_sink
    if (rst_ni) begin
      if (res_fired) res_stall = no_idle ? 0 : $urandom_range(0, 12);
      if (res_stall > 0) begin
        res_stall--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [rag_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (seed_q.size() != 0 || seed_valid || attitude_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic add_random(input int n);
    for (int i = 0; i < n; i++) seed_q.push_back({$urandom(), $urandom()});
  endtask

  // Stimulus phases.
  initial begin : stimulus
    logic [31:0] a, b;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed seeds at the reset bounds, where every speed is zero.
    seed_q.push_back(64'd0);
    seed_q.push_back('1);
    seed_q.push_back(64'd1);
    seed_q.push_back(64'h8000_0000_0000_0000);
    seed_q.push_back(64'h5555_5555_5555_5555);
    seed_q.push_back(64'hAAAA_AAAA_AAAA_AAAA);
    wait_drained();

    // Widest range of speeds.
    write_reg(rag_pkg::REG_MIN_SPEED, 32'd0);
    write_reg(rag_pkg::REG_MAX_SPEED, 32'hFFFF_FFFF);
    seed_q.push_back(64'd0);
    seed_q.push_back('1);
    seed_q.push_back(64'h0123_4567_89AB_CDEF);
    add_random(3);
    wait_drained();

    // Equal bounds at the top, then a write to an unused index.
    write_reg(rag_pkg::REG_MIN_SPEED, 32'hFFFF_FFFF);
    write_reg(8'hFF, 32'd0);
    seed_q.push_back('1);
    add_random(3);
    wait_drained();

    // Bounds error: maximum below minimum.
    write_reg(rag_pkg::REG_MAX_SPEED, 32'd0);
    seed_q.push_back(64'd0);
    seed_q.push_back('1);
    add_random(2);
    wait_drained();

    // Random phases with random bounds, some inverted; one run without idling.
    for (int ph = 0; ph < 14; ph++) begin
      a = $urandom();
      b = $urandom();
      if (ph % 5 == 0) b = a;
      if (ph % 4 != 3 && b < a) begin
        logic [31:0] t;
        t = a; a = b; b = t;
      end
      write_reg(rag_pkg::REG_MIN_SPEED, a);
      write_reg(rag_pkg::REG_MAX_SPEED, b);
      no_idle = (ph == 6);
      add_random(100);
      wait_drained();
    end
    no_idle = 0;

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #200_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
